// ===== src/tomm_pkg.sv =====
package tomm_pkg;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_STEP   = 2'd1,
    FUNC_REWIND = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_EVENT     = 3'd0,
    ST_EXHAUSTED = 3'd1,
    ST_ACCEPTED  = 3'd2,
    ST_FULL      = 3'd3,
    ST_ACK       = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AP_CHK,
    S_AP_RD,
    S_AP_CMP,
    S_AP_WR,
    S_SC_RD,
    S_SC_CMP,
    S_EM_CHK,
    S_EM_RD,
    S_EM_CMP,
    S_EM_OUT,
    S_OUT
  } state_e;

  localparam logic [63:0] TimeSentinel = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int unsigned WordBits = 64;

  typedef struct packed {
    logic [WordBits-1:0] time_w;
    logic [WordBits-1:0] open_w;
    logic [WordBits-1:0] high_w;
    logic [WordBits-1:0] low_w;
    logic [WordBits-1:0] close_w;
    logic [WordBits-1:0] volume_w;
  } bar_t;

endpackage

// ===== src/tomm_store.sv =====
module tomm_store #(
  parameter int unsigned Depth = 2048,
  parameter int unsigned AddrW = 11
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  tomm_pkg::bar_t    wdata_i,
  input  logic [AddrW-1:0]  raddr_i,
  output tomm_pkg::bar_t    rdata_o
);
  import tomm_pkg::*;

  bar_t mem [Depth];

  // Registered read, write-first not needed: sequencer never reads a slot it writes.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== src/timestamp_ordered_multichannel_merge.sv =====
// Sequence: rewind and clear go straight to the result register load; append walks
//   down from the fill count, comparing m slots (at most the fill count), then writes; a full append skips the walk.
// Step: reads and compares each channel's head, then decides (exhausted ends there),
//   then walks the channels up to the last match, loading one event per matching head.
// One item at a time: in_ready_o returns after the last result loads; the single
//   memory read port serialises the walks. Reset clears fill counts, read positions and
//   merge time; bar memory is not cleared.
module timestamp_ordered_multichannel_merge #(
  parameter int unsigned NUM_CHANNELS     = 8,
  parameter int unsigned BARS_PER_CHANNEL = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [2:0]  channel_i,
  input  logic [63:0] bar_time_i,
  input  logic [63:0] open_bits_i,
  input  logic [63:0] high_bits_i,
  input  logic [63:0] low_bits_i,
  input  logic [63:0] close_bits_i,
  input  logic [63:0] volume_bits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [2:0]  event_channel_o,
  output logic [63:0] event_time_o,
  output logic [63:0] out_open_o,
  output logic [63:0] out_high_o,
  output logic [63:0] out_low_o,
  output logic [63:0] out_close_o,
  output logic [63:0] out_volume_o,
  output logic        last_o
);
  import tomm_pkg::*;

  localparam int unsigned ChW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned PosW  = (BARS_PER_CHANNEL > 1) ? $clog2(BARS_PER_CHANNEL) : 1;
  localparam int unsigned CntW  = $clog2(BARS_PER_CHANNEL + 1);
  localparam int unsigned Depth = NUM_CHANNELS * BARS_PER_CHANNEL;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  state_e state_q, state_d;

  logic [CntW-1:0] fill_q [NUM_CHANNELS];
  logic [CntW-1:0] rpos_q [NUM_CHANNELS];
  logic [63:0]     merge_time_q;

  // Held copy of the accepted item.
  func_e       func_q;
  logic [2:0]  chan_q;
  bar_t        bar_q;

  // Sequencer working registers.
  logic [CntW-1:0] pos_q;      // append insertion walk position
  logic [ChW-1:0]  cidx_q;     // channel walk counter
  logic [ChW-1:0]  last_ch_q;  // highest channel whose head equals the minimum
  logic [63:0]     best_q;
  logic            any_q;
  logic            full_q;

  // Output register.
  logic        ov_q;
  status_e     ost_q;
  logic [2:0]  och_q;
  logic [63:0] otm_q;
  bar_t        obar_q;
  logic        olast_q;

  // Memory port.
  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  bar_t             wdata, rdata;

  tomm_store #(.Depth(Depth), .AddrW(AddrW)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic [ChW-1:0]  in_ch;
  logic            chan_ok;
  logic            head_ok;
  logic            at_last_ch;
  logic            out_free;
  logic [CntW-1:0] pos_m1;

  assign in_ch      = ChW'(chan_q);
  assign chan_ok    = (32'(chan_q) < NUM_CHANNELS);
  assign head_ok    = (rpos_q[cidx_q] < fill_q[cidx_q]);
  assign at_last_ch = (cidx_q == ChW'(NUM_CHANNELS - 1));
  assign out_free   = !ov_q || out_ready_i;
  assign pos_m1     = pos_q - CntW'(1);

  function automatic logic [AddrW-1:0] slot_addr(input logic [ChW-1:0] ch,
                                                 input logic [PosW-1:0] pos);
    return AddrW'(ch) * AddrW'(BARS_PER_CHANNEL) + AddrW'(pos);
  endfunction

  // Shared 64-bit compare unit: one comparison per sequencer beat.
  logic [63:0] cmp_b;
  logic        cmp_gt, cmp_lt, cmp_eq;
  always_comb begin
    cmp_b = (state_q == S_AP_CMP) ? bar_q.time_w : best_q;
  end
  assign cmp_lt = rdata.time_w < cmp_b;
  assign cmp_eq = rdata.time_w == cmp_b;
  assign cmp_gt = !cmp_lt && !cmp_eq;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (func_e'(func_i))
            FUNC_APPEND: state_d = S_AP_CHK;
            FUNC_STEP:   state_d = S_SC_RD;
            default:     state_d = S_OUT;
          endcase
        end
      end
      S_AP_CHK: begin
        if (!chan_ok || fill_q[in_ch] >= CntW'(BARS_PER_CHANNEL)) state_d = S_OUT;
        else if (fill_q[in_ch] == '0) state_d = S_AP_WR;
        else state_d = S_AP_RD;
      end
      S_AP_RD:  state_d = S_AP_CMP;
      S_AP_CMP: state_d = (cmp_gt && pos_m1 != '0) ? S_AP_RD : S_AP_WR;
      S_AP_WR:  state_d = S_OUT;
      S_SC_RD:  state_d = S_SC_CMP;
      S_SC_CMP: state_d = at_last_ch ? S_EM_CHK : S_SC_RD;
      S_EM_CHK: state_d = (!any_q || best_q == TimeSentinel) ? S_OUT : S_EM_RD;
      S_EM_RD:  state_d = S_EM_CMP;
      S_EM_CMP: state_d = (head_ok && cmp_eq) ? S_EM_OUT : S_EM_RD;
      S_EM_OUT: begin
        if (out_free) state_d = (cidx_q == last_ch_q) ? S_IDLE : S_EM_RD;
      end
      S_OUT:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Memory addressing: by default read the head of the walked channel, so the
  // head bar stays on rdata while an event waits for the output register.
  always_comb begin
    raddr = slot_addr(cidx_q, rpos_q[cidx_q][PosW-1:0]);
    waddr = slot_addr(in_ch, pos_q[PosW-1:0]);
    wdata = bar_q;
    we    = 1'b0;
    unique case (state_q)
      S_AP_RD: raddr = slot_addr(in_ch, pos_m1[PosW-1:0]);
      S_AP_CMP: begin
        // Shift the larger bar up one slot.
        we    = cmp_gt;
        wdata = rdata;
      end
      S_AP_WR: we = 1'b1;
      default: ;
    endcase
  end

  // Sequencer and channel state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        fill_q[i] <= '0;
        rpos_q[i] <= '0;
      end
      merge_time_q <= '0;
      state_q      <= S_IDLE;
      func_q       <= FUNC_APPEND;
      chan_q       <= '0;
      bar_q        <= '0;
      pos_q        <= '0;
      cidx_q       <= '0;
      last_ch_q    <= '0;
      best_q       <= '0;
      any_q        <= 1'b0;
      full_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            func_q    <= func_e'(func_i);
            chan_q    <= channel_i;
            bar_q     <= '{bar_time_i, open_bits_i, high_bits_i, low_bits_i,
                           close_bits_i, volume_bits_i};
            cidx_q    <= '0;
            last_ch_q <= '0;
            best_q    <= TimeSentinel;
            any_q     <= 1'b0;
          end
        end
        S_AP_CHK: begin
          pos_q  <= fill_q[in_ch];
          full_q <= !chan_ok || fill_q[in_ch] >= CntW'(BARS_PER_CHANNEL);
        end
        S_AP_CMP: if (cmp_gt) pos_q <= pos_m1;
        S_AP_WR:  fill_q[in_ch] <= fill_q[in_ch] + CntW'(1);
        S_SC_CMP: begin
          // Track the minimum head and the highest channel that holds it.
          if (head_ok) begin
            any_q <= 1'b1;
            if (cmp_lt) begin
              best_q    <= rdata.time_w;
              last_ch_q <= cidx_q;
            end else if (cmp_eq) begin
              last_ch_q <= cidx_q;
            end
          end
          cidx_q <= at_last_ch ? '0 : cidx_q + ChW'(1);
        end
        S_EM_CHK: if (any_q && best_q != TimeSentinel) merge_time_q <= best_q;
        S_EM_CMP: if (!(head_ok && cmp_eq)) cidx_q <= cidx_q + ChW'(1);
        S_EM_OUT: begin
          if (out_free) begin
            rpos_q[cidx_q] <= rpos_q[cidx_q] + CntW'(1);
            cidx_q         <= cidx_q + ChW'(1);
          end
        end
        S_OUT: begin
          if (out_free) begin
            if (func_q == FUNC_REWIND) begin
              for (int i = 0; i < NUM_CHANNELS; i++) rpos_q[i] <= '0;
              merge_time_q <= '0;
            end else if (func_q == FUNC_CLEAR && chan_ok) begin
              fill_q[in_ch] <= '0;
              rpos_q[in_ch] <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Output register load.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q    <= 1'b0;
      ost_q   <= ST_ACK;
      och_q   <= '0;
      otm_q   <= '0;
      obar_q  <= '0;
      olast_q <= 1'b0;
    end else if (state_q == S_EM_OUT && out_free) begin
      ov_q    <= 1'b1;
      ost_q   <= ST_EVENT;
      och_q   <= 3'(cidx_q);
      otm_q   <= best_q;
      obar_q  <= rdata;
      olast_q <= (cidx_q == last_ch_q);
    end else if (state_q == S_OUT && out_free) begin
      ov_q    <= 1'b1;
      obar_q  <= '0;
      olast_q <= 1'b1;
      unique case (func_q)
        FUNC_APPEND: begin
          ost_q <= full_q ? ST_FULL : ST_ACCEPTED;
          och_q <= chan_q;
          otm_q <= bar_q.time_w;
        end
        FUNC_STEP: begin
          ost_q <= ST_EXHAUSTED;
          och_q <= '0;
          otm_q <= merge_time_q;
        end
        FUNC_REWIND: begin
          ost_q <= ST_ACK;
          och_q <= '0;
          otm_q <= '0;
        end
        default: begin
          ost_q <= ST_ACK;
          och_q <= chan_q;
          otm_q <= merge_time_q;
        end
      endcase
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  assign out_valid_o     = ov_q;
  assign status_o        = ost_q;
  assign event_channel_o = och_q;
  assign event_time_o    = otm_q;
  assign out_open_o      = obar_q.open_w;
  assign out_high_o      = obar_q.high_w;
  assign out_low_o       = obar_q.low_w;
  assign out_close_o     = obar_q.close_w;
  assign out_volume_o    = obar_q.volume_w;
  assign last_o          = olast_q;

  // Never accept an item while the sequencer is busy.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o)
    else $error("ready during busy");
  // Channel 0's fill count never passes the channel depth.
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q[0] <= CntW'(BARS_PER_CHANNEL))
    else $error("fill overflow");
  // A held result stays valid with last, status and event time unchanged.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(last_o) && $stable(status_o) && $stable(event_time_o)))
    else $error("result changed");

endmodule
